// ===== sv/upr_pkg.sv =====
// ----------------------------------------------------------------------------
// upr_pkg: shared types and constants of the ultrasonic pair ranging sequencer
// Register codes, field widths, sequencer phases, steer codes and the beat
// records that travel between the sequencer, the echo lanes and the merge stage.
// ----------------------------------------------------------------------------
package upr_pkg;

  // Number of sensor pairs visited in one sweep
  localparam int unsigned PAIRS = 5;
  localparam int unsigned PAIR_W = 3;
  localparam int unsigned TRIG_W = 8;
  localparam int unsigned CHAN_W = 4;

  localparam int unsigned TIME_W = 16;
  localparam int unsigned TRIGT_W = 8;
  localparam int unsigned GAP_W = 20;
  localparam int unsigned SCALE_W = 16;
  localparam int unsigned DIST_W = 19;
  localparam int unsigned PROD_W = TIME_W + SCALE_W;
  localparam int unsigned DIST_SHIFT = 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 20;

  // Trigger lines of the pairs that exist, all idle
  localparam logic [TRIG_W-1:0] IDLE_MASK = TRIG_W'((1 << PAIRS) - 1);
  localparam logic [CHAN_W-1:0] PAIRS_CHAN = CHAN_W'(PAIRS);
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // Register reset values
  localparam logic [TIME_W-1:0] TIMEOUT_RST = 16'd15000;
  localparam logic [TRIGT_W-1:0] TRIGGER_RST = 8'd5;
  localparam logic [GAP_W-1:0] GAP_RST = 20'd200000;
  localparam logic [SCALE_W-1:0] SCALE_RST = 16'd1114;
  localparam logic [CHAN_W-1:0] WATCH_RST = 4'd8;
  localparam logic [DIST_W-1:0] NEAR_RST = 19'd2048;
  localparam logic [DIST_W-1:0] FAR_RST = 19'd2304;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TIMEOUT = 3'd0,
    REG_TRIGGER = 3'd1,
    REG_GAP     = 3'd2,
    REG_SCALE   = 3'd3,
    REG_WATCH   = 3'd4,
    REG_NEAR    = 3'd5,
    REG_FAR     = 3'd6
  } reg_idx_e;

  typedef enum logic [2:0] {
    PH_TRIGGER = 3'b001,
    PH_LISTEN  = 3'b010,
    PH_GAP     = 3'b100
  } phase_e;

  typedef enum logic [1:0] {
    STEER_RIGHT = 2'd0,
    STEER_AHEAD = 2'd1,
    STEER_LEFT  = 2'd2
  } steer_e;

  typedef struct packed {
    logic [TIME_W-1:0]  timeout_ticks;
    logic [TRIGT_W-1:0] trigger_ticks;
    logic [GAP_W-1:0]   gap_ticks;
    logic [SCALE_W-1:0] distance_scale;
    logic [CHAN_W-1:0]  watch_channel;
    logic [DIST_W-1:0]  near_threshold;
    logic [DIST_W-1:0]  far_threshold;
  } cfg_t;

  // Per-beat record from the sequencer
  typedef struct packed {
    logic [TRIG_W-1:0] trig;
    logic              done;
    logic [PAIR_W-1:0] idx;
    logic              sweep;
  } tick_t;

  // Lane controls
  typedef struct packed {
    logic tick;    // beat accepted
    logic sample;  // echo level is watched this beat
    logic clear;   // pair finished, restart stamps
    logic adv;     // width stage moves into distance stage
  } lane_ctl_t;

  typedef struct packed {
    logic [TRIG_W-1:0] trigger_lines;
    logic              pair_done;
    logic [PAIR_W-1:0] pair_index;
    logic [TIME_W-1:0] width_a;
    logic [TIME_W-1:0] width_b;
    logic [DIST_W-1:0] distance_a;
    logic [DIST_W-1:0] distance_b;
    logic              sweep_done;
    logic [1:0]        steer;
  } res_t;

endpackage

// ===== sv/upr_if.sv =====
// ----------------------------------------------------------------------------
// upr_if: handshake channels of the ranging sequencer
// Echo tick input, result output and register write channel.
// ----------------------------------------------------------------------------
interface upr_in_if;
  logic valid;
  logic ready;
  logic echo_a;
  logic echo_b;
  modport source (output valid, echo_a, echo_b, input ready);
  modport sink (input valid, echo_a, echo_b, output ready);
endinterface

interface upr_out_if;
  logic                         valid;
  logic                         ready;
  logic [upr_pkg::TRIG_W-1:0]   trigger_lines;
  logic                         pair_done;
  logic [upr_pkg::PAIR_W-1:0]   pair_index;
  logic [upr_pkg::TIME_W-1:0]   width_a;
  logic [upr_pkg::TIME_W-1:0]   width_b;
  logic [upr_pkg::DIST_W-1:0]   distance_a;
  logic [upr_pkg::DIST_W-1:0]   distance_b;
  logic                         sweep_done;
  logic [1:0]                   steer;
  modport source (output valid, trigger_lines, pair_done, pair_index, width_a, width_b,
                  distance_a, distance_b, sweep_done, steer, input ready);
  modport sink (input valid, trigger_lines, pair_done, pair_index, width_a, width_b,
                distance_a, distance_b, sweep_done, steer, output ready);
endinterface

interface upr_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [upr_pkg::CFG_IDX_W-1:0]   index;
  logic [upr_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/upr_seq.sv =====
// ----------------------------------------------------------------------------
// upr_seq: pair sequencer
// Walks trigger, listen and gap phases one beat at a time, keeps the elapsed
// and gap counters, and decides when a pair and a sweep are finished.
// ----------------------------------------------------------------------------
module upr_seq (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  upr_pkg::cfg_t               cfg_i,
  input  logic                        ended_a_i,
  input  logic                        ended_b_i,
  output logic [upr_pkg::TIME_W-1:0]  stamp_o,
  output logic                        sample_o,
  output logic                        clear_o,
  output upr_pkg::tick_t              tick_o
);

  upr_pkg::phase_e                   phase_q, phase_d;
  logic [upr_pkg::PAIR_W-1:0]        pair_q, pair_d;
  logic [upr_pkg::TIME_W-1:0]        elapsed_q, elapsed_d, elapsed_inc;
  logic [upr_pkg::GAP_W-1:0]         gap_q, gap_d, gap_inc;
  logic                              timed_out, fin, last_pair;

  // Saturating counter steps
  assign elapsed_inc = (elapsed_q != '1) ? elapsed_q + 1'b1 : elapsed_q;
  assign gap_inc = (gap_q != '1) ? gap_q + 1'b1 : gap_q;
  assign last_pair = ({1'b0, pair_q} + 4'd1) >= 4'(upr_pkg::PAIRS);
  assign timed_out = elapsed_q >= cfg_i.timeout_ticks;
  assign stamp_o = elapsed_q;

  // Next phase and beat record
  always_comb begin
    phase_d = phase_q;
    pair_d = pair_q;
    elapsed_d = elapsed_q;
    gap_d = gap_q;
    sample_o = 1'b0;
    clear_o = 1'b0;
    fin = 1'b0;
    tick_o = '{trig: upr_pkg::IDLE_MASK, done: 1'b0, idx: pair_q, sweep: 1'b0};
    unique case (phase_q)
      upr_pkg::PH_TRIGGER: begin
        tick_o.trig = upr_pkg::IDLE_MASK & ~(upr_pkg::TRIG_W'(1) << pair_q);
        elapsed_d = elapsed_inc;
        if (elapsed_inc >= {8'd0, cfg_i.trigger_ticks}) begin
          phase_d = upr_pkg::PH_LISTEN;
        end
      end
      upr_pkg::PH_LISTEN: begin
        sample_o = !timed_out;
        fin = timed_out || (ended_a_i && ended_b_i);
        elapsed_d = elapsed_inc;
        if (fin) begin
          tick_o.done = 1'b1;
          clear_o = 1'b1;
          elapsed_d = '0;
          phase_d = upr_pkg::PH_TRIGGER;
          if (last_pair) begin
            tick_o.sweep = 1'b1;
            pair_d = '0;
            gap_d = '0;
            if (cfg_i.gap_ticks != '0) begin
              phase_d = upr_pkg::PH_GAP;
            end
          end else begin
            pair_d = pair_q + 1'b1;
          end
        end
      end
      upr_pkg::PH_GAP: begin
        tick_o.idx = '0;
        gap_d = gap_inc;
        if (gap_inc >= cfg_i.gap_ticks) begin
          pair_d = '0;
          elapsed_d = '0;
          clear_o = 1'b1;
          phase_d = upr_pkg::PH_TRIGGER;
        end
      end
      default: begin
        phase_d = upr_pkg::PH_TRIGGER;
      end
    endcase
  end

  // Advance on each accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= upr_pkg::PH_TRIGGER;
      pair_q <= '0;
      elapsed_q <= '0;
      gap_q <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      pair_q <= pair_d;
      elapsed_q <= elapsed_d;
      gap_q <= gap_d;
    end
  end

endmodule

// ===== sv/upr_lane.sv =====
// ----------------------------------------------------------------------------
// upr_lane: one echo lane
// Stamps the rising and falling edge of the echo, forms the pulse width and
// scales it to a saturated Q8 distance in a registered multiply stage.
// ----------------------------------------------------------------------------
module upr_lane (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  upr_pkg::lane_ctl_t          ctl_i,
  input  logic                        level_i,
  input  logic [upr_pkg::TIME_W-1:0]  stamp_i,
  input  upr_pkg::cfg_t               cfg_i,
  output logic                        ended_o,
  output logic [upr_pkg::TIME_W-1:0]  width_o,
  output logic [upr_pkg::DIST_W-1:0]  distance_o
);

  logic                              started_q, started_d, ended_q, ended_d;
  logic [upr_pkg::TIME_W-1:0]        start_q, start_d, end_q, end_d;
  logic [upr_pkg::TIME_W-1:0]        width_s0, width1_q, width2_q;
  logic [upr_pkg::PROD_W-1:0]        product;
  logic [upr_pkg::PROD_W-upr_pkg::DIST_SHIFT-1:0] scaled;
  logic [upr_pkg::DIST_W-1:0]        dist_sat, dist2_q;

  // Edge stamping for this beat
  always_comb begin
    started_d = started_q;
    ended_d = ended_q;
    start_d = start_q;
    end_d = end_q;
    if (ctl_i.sample) begin
      if (!started_q) begin
        if (level_i) begin
          start_d = stamp_i;
          started_d = 1'b1;
        end
      end else if (!ended_q && !level_i) begin
        end_d = stamp_i;
        ended_d = 1'b1;
      end
    end
  end

  assign ended_o = ended_d;
  assign width_s0 = ended_d ? end_d - start_d : cfg_i.timeout_ticks;

  // Hold stamps, drop them when the pair finishes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      ended_q <= 1'b0;
      start_q <= '0;
      end_q <= '0;
    end else if (ctl_i.tick) begin
      if (ctl_i.clear) begin
        started_q <= 1'b0;
        ended_q <= 1'b0;
        start_q <= '0;
        end_q <= '0;
      end else begin
        started_q <= started_d;
        ended_q <= ended_d;
        start_q <= start_d;
        end_q <= end_d;
      end
    end
  end

  // Scale width to distance and saturate
  assign product = width1_q * cfg_i.distance_scale;
  assign scaled = product[upr_pkg::PROD_W-1:upr_pkg::DIST_SHIFT];
  assign dist_sat =
    (scaled > {{(upr_pkg::PROD_W-upr_pkg::DIST_SHIFT-upr_pkg::DIST_W){1'b0}},
               upr_pkg::DIST_MAX})
    ? upr_pkg::DIST_MAX : scaled[upr_pkg::DIST_W-1:0];

  // Width and distance stages
  always_ff @(posedge clk_i) begin
    if (ctl_i.tick) begin
      width1_q <= width_s0;
    end
    if (ctl_i.adv) begin
      width2_q <= width1_q;
      dist2_q <= dist_sat;
    end
  end

  assign width_o = width2_q;
  assign distance_o = dist2_q;

endmodule

// ===== sv/upr_merge.sv =====
// ----------------------------------------------------------------------------
// upr_merge: merge stage
// Combines both lanes with the beat record, tracks the watched distance and
// forms the steer code at the end of a sweep into the result register.
// ----------------------------------------------------------------------------
module upr_merge (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  upr_pkg::tick_t              tick_i,
  input  upr_pkg::cfg_t               cfg_i,
  input  logic [upr_pkg::TIME_W-1:0]  width_a_i,
  input  logic [upr_pkg::TIME_W-1:0]  width_b_i,
  input  logic [upr_pkg::DIST_W-1:0]  distance_a_i,
  input  logic [upr_pkg::DIST_W-1:0]  distance_b_i,
  output upr_pkg::res_t               res_o
);

  logic [upr_pkg::DIST_W-1:0]  watched_q, watched_d;
  logic [upr_pkg::CHAN_W-1:0]  chan_a, chan_b;
  upr_pkg::res_t               res_d, res_q;

  assign chan_a = {1'b0, tick_i.idx};
  assign chan_b = chan_a + upr_pkg::PAIRS_CHAN;

  // Pick the watched channel and steer
  always_comb begin
    watched_d = watched_q;
    if (tick_i.done) begin
      if (cfg_i.watch_channel == chan_a) begin
        watched_d = distance_a_i;
      end else if (cfg_i.watch_channel == chan_b) begin
        watched_d = distance_b_i;
      end
    end
    res_d.trigger_lines = tick_i.trig;
    res_d.pair_done = tick_i.done;
    res_d.pair_index = tick_i.idx;
    res_d.width_a = tick_i.done ? width_a_i : '0;
    res_d.width_b = tick_i.done ? width_b_i : '0;
    res_d.distance_a = tick_i.done ? distance_a_i : '0;
    res_d.distance_b = tick_i.done ? distance_b_i : '0;
    res_d.sweep_done = tick_i.sweep;
    res_d.steer = upr_pkg::STEER_RIGHT;
    if (tick_i.sweep) begin
      if (watched_d < cfg_i.near_threshold) begin
        res_d.steer = upr_pkg::STEER_RIGHT;
      end else if (watched_d < cfg_i.far_threshold) begin
        res_d.steer = upr_pkg::STEER_AHEAD;
      end else begin
        res_d.steer = upr_pkg::STEER_LEFT;
      end
    end
  end

  // Hold the watched distance across beats
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      watched_q <= '0;
    end else if (adv_i) begin
      watched_q <= watched_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

// ===== sv/ultrasonic_pair_ranging_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// ultrasonic_pair_ranging_sequencer_unit: ultrasonic pair ranging sequencer
// Top level: register file, beat pipeline, sequencer, two echo lanes, merge.
// ----------------------------------------------------------------------------
// One input beat is one microsecond tick carrying both echo levels, and every
// beat gives exactly one result beat. A new beat is taken every clock cycle
// unless the result channel stalls the pipeline; the result passes through the
// sequencer stage, the width-times-scale multiply stage in each lane and the
// merge register. Ready stalls only as far back as the pipeline is full.
// Registers may be written only while no beat is in flight; the write port is
// always ready. There is no clearing pass after reset.
module ultrasonic_pair_ranging_sequencer_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  upr_in_if.sink       in_i,
  upr_out_if.source    out_o,
  upr_cfg_if.sink      cfg_i
);

  upr_pkg::cfg_t              cfg_q;
  logic                       v1_q, v2_q, v3_q;
  logic                       r1, r2, r3;
  logic                       accept, adv2, adv3;
  logic                       ended_a, ended_b, sample, clear;
  logic [upr_pkg::TIME_W-1:0] stamp;
  upr_pkg::tick_t             tick_s0, tick1_q, tick2_q;
  upr_pkg::lane_ctl_t         lane_ctl;
  logic [upr_pkg::TIME_W-1:0] width_a, width_b;
  logic [upr_pkg::DIST_W-1:0] dist_a, dist_b;
  upr_pkg::res_t              res;

  // Register writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout_ticks <= upr_pkg::TIMEOUT_RST;
      cfg_q.trigger_ticks <= upr_pkg::TRIGGER_RST;
      cfg_q.gap_ticks <= upr_pkg::GAP_RST;
      cfg_q.distance_scale <= upr_pkg::SCALE_RST;
      cfg_q.watch_channel <= upr_pkg::WATCH_RST;
      cfg_q.near_threshold <= upr_pkg::NEAR_RST;
      cfg_q.far_threshold <= upr_pkg::FAR_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        upr_pkg::REG_TIMEOUT: cfg_q.timeout_ticks <= cfg_i.data[upr_pkg::TIME_W-1:0];
        upr_pkg::REG_TRIGGER: cfg_q.trigger_ticks <= cfg_i.data[upr_pkg::TRIGT_W-1:0];
        upr_pkg::REG_GAP:     cfg_q.gap_ticks <= cfg_i.data[upr_pkg::GAP_W-1:0];
        upr_pkg::REG_SCALE:   cfg_q.distance_scale <= cfg_i.data[upr_pkg::SCALE_W-1:0];
        upr_pkg::REG_WATCH:   cfg_q.watch_channel <= cfg_i.data[upr_pkg::CHAN_W-1:0];
        upr_pkg::REG_NEAR:    cfg_q.near_threshold <= cfg_i.data[upr_pkg::DIST_W-1:0];
        upr_pkg::REG_FAR:     cfg_q.far_threshold <= cfg_i.data[upr_pkg::DIST_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow control
  assign r3 = !v3_q || out_o.ready;
  assign r2 = !v2_q || r3;
  assign r1 = !v1_q || r2;
  assign in_i.ready = r1;
  assign accept = in_i.valid && r1;
  assign adv2 = v1_q && r2;
  assign adv3 = v2_q && r3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (r1) v1_q <= in_i.valid;
      if (r2) v2_q <= v1_q;
      if (r3) v3_q <= v2_q;
    end
  end

  // Beat record stages
  always_ff @(posedge clk_i) begin
    if (accept) tick1_q <= tick_s0;
    if (adv2) tick2_q <= tick1_q;
  end

  upr_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .cfg_i     (cfg_q),
    .ended_a_i (ended_a),
    .ended_b_i (ended_b),
    .stamp_o   (stamp),
    .sample_o  (sample),
    .clear_o   (clear),
    .tick_o    (tick_s0)
  );

  assign lane_ctl = '{tick: accept, sample: sample, clear: clear, adv: adv2};

  upr_lane u_lane_a (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (lane_ctl),
    .level_i    (in_i.echo_a),
    .stamp_i    (stamp),
    .cfg_i      (cfg_q),
    .ended_o    (ended_a),
    .width_o    (width_a),
    .distance_o (dist_a)
  );

  upr_lane u_lane_b (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (lane_ctl),
    .level_i    (in_i.echo_b),
    .stamp_i    (stamp),
    .cfg_i      (cfg_q),
    .ended_o    (ended_b),
    .width_o    (width_b),
    .distance_o (dist_b)
  );

  upr_merge u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv3),
    .tick_i       (tick2_q),
    .cfg_i        (cfg_q),
    .width_a_i    (width_a),
    .width_b_i    (width_b),
    .distance_a_i (dist_a),
    .distance_b_i (dist_b),
    .res_o        (res)
  );

  // Result beat
  assign out_o.valid = v3_q;
  assign out_o.trigger_lines = res.trigger_lines;
  assign out_o.pair_done = res.pair_done;
  assign out_o.pair_index = res.pair_index;
  assign out_o.width_a = res.width_a;
  assign out_o.width_b = res.width_b;
  assign out_o.distance_a = res.distance_a;
  assign out_o.distance_b = res.distance_b;
  assign out_o.sweep_done = res.sweep_done;
  assign out_o.steer = res.steer;

endmodule

// ===== sv/upr_checker.sv =====
// ----------------------------------------------------------------------------
// upr_checker: port-level checks of the ranging sequencer
// Watches the result channel and flags malformed or unstable result beats.
// ----------------------------------------------------------------------------
module upr_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        valid_i,
  input logic                        ready_i,
  input logic [upr_pkg::TRIG_W-1:0]  trigger_lines_i,
  input logic                        pair_done_i,
  input logic [upr_pkg::PAIR_W-1:0]  pair_index_i,
  input logic [upr_pkg::TIME_W-1:0]  width_a_i,
  input logic [upr_pkg::TIME_W-1:0]  width_b_i,
  input logic                        sweep_done_i,
  input logic [1:0]                  steer_i
);

  // A sweep ends only with the report of the last pair
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && sweep_done_i |->
      pair_done_i && (pair_index_i == upr_pkg::PAIR_W'(upr_pkg::PAIRS - 1)))
    else $error("sweep_done without report of last pair");

  // At most one existing trigger line low, lines beyond the pairs held at zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> ((trigger_lines_i & ~upr_pkg::IDLE_MASK) == '0) &&
      ($countones(~trigger_lines_i & upr_pkg::IDLE_MASK) <= 1))
    else $error("bad trigger line pattern");

  // No trigger pulse on a reporting beat, widths zero when not reporting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> (pair_done_i ? (trigger_lines_i == upr_pkg::IDLE_MASK)
                             : (width_a_i == '0 && width_b_i == '0)))
    else $error("report beat malformed");

  // Steer only on sweep end and never an unused code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> (steer_i != 2'd3) && (sweep_done_i || steer_i == upr_pkg::STEER_RIGHT))
    else $error("bad steer code");

  // A stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i && $stable(trigger_lines_i) && $stable(pair_done_i) &&
      $stable(pair_index_i) && $stable(width_a_i) && $stable(sweep_done_i))
    else $error("stalled result beat changed");

endmodule

bind ultrasonic_pair_ranging_sequencer_unit upr_checker u_upr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .valid_i         (out_o.valid),
  .ready_i         (out_o.ready),
  .trigger_lines_i (out_o.trigger_lines),
  .pair_done_i     (out_o.pair_done),
  .pair_index_i    (out_o.pair_index),
  .width_a_i       (out_o.width_a),
  .width_b_i       (out_o.width_b),
  .sweep_done_i    (out_o.sweep_done),
  .steer_i         (out_o.steer)
);
